// File: sv/fgrs_pkg.sv
// Shared constants and types for the filtered gap rescue selector.
package fgrs_pkg;

  // Buffer geometry
  localparam int REGION_DEPTH = 32;
  localparam int FILL_W       = $clog2(REGION_DEPTH + 1);

  // Field widths
  localparam int POS_W = 16;
  localparam int CNT_W = 32;
  localparam int THR_W = 16;

  // Running multiple of the threshold: up to (REGION_DEPTH + 2) * threshold
  localparam int ACC_W = THR_W + $clog2(REGION_DEPTH + 2);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(100);

  // One buffered filtered hit
  typedef struct packed {
    logic [POS_W-1:0] num;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              insert;
    logic              pop;
    logic [FILL_W-1:0] fill;
    entry_t            new_entry;
  } cell_ctl_t;

endpackage

// File: sv/fgrs_hit_if.sv
// Input channel: one seed hit per transaction.
interface fgrs_hit_if import fgrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] seed_start;
  logic             hit_filtered;
  logic [CNT_W-1:0] occurrence_count;
  logic             read_last;

  modport source (
    output valid, seed_start, hit_filtered, occurrence_count, read_last,
    input  ready
  );
  modport sink (
    input  valid, seed_start, hit_filtered, occurrence_count, read_last,
    output ready
  );
endinterface

// File: sv/fgrs_rescue_if.sv
// Output channel: one rescued hit per transaction.
interface fgrs_rescue_if import fgrs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] rescued_hit_number;
  logic             run_last;
  logic             buffer_overflow;

  modport source (
    output valid, rescued_hit_number, run_last, buffer_overflow,
    input  ready
  );
  modport sink (
    input  valid, rescued_hit_number, run_last, buffer_overflow,
    output ready
  );
endinterface

// File: sv/fgrs_cell.sv
// One slot of the sorted hit chain: holds an entry, shifts on insert or pop.
module fgrs_cell import fgrs_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [FILL_W-1:0] slot,
  input  logic              prev_lt,
  input  entry_t            prev_entry,
  input  entry_t            next_entry,
  output logic              lt,
  output entry_t            entry
);

  // New entry belongs at or before this slot (empty slots act as +inf).
  // Equal counts keep the older entry first.
  assign lt = (slot >= ctl.fill) || (ctl.new_entry.cnt < entry.cnt);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (prev_lt) begin
        entry <= prev_entry;
      end else if (lt) begin
        entry <= ctl.new_entry;
      end
    end else if (ctl.pop) begin
      entry <= next_entry;
    end
  end

endmodule

// File: sv/fgrs_chain.sv
// Row of cells kept in ascending count order; the head is the next to rescue.
module fgrs_chain import fgrs_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  output entry_t    head
);

  entry_t entries [REGION_DEPTH];
  logic   lts     [REGION_DEPTH];

  genvar i;
  generate
    for (i = 0; i < REGION_DEPTH; i++) begin : g_cell
      entry_t prev_e;
      entry_t next_e;
      logic   prev_l;

      // Neighbor hookup; the ends see constants or themselves
      if (i == 0) begin : g_first
        assign prev_l = 1'b0;
        assign prev_e = entries[0];
      end else begin : g_mid
        assign prev_l = lts[i-1];
        assign prev_e = entries[i-1];
      end
      if (i == REGION_DEPTH - 1) begin : g_tail
        assign next_e = entries[i];
      end else begin : g_body
        assign next_e = entries[i+1];
      end

      fgrs_cell u_cell (
        .clk        (clk),
        .ctl        (ctl),
        .slot       (FILL_W'(i)),
        .prev_lt    (prev_l),
        .prev_entry (prev_e),
        .next_entry (next_e),
        .lt         (lts[i]),
        .entry      (entries[i])
      );
    end
  endgenerate

  assign head = entries[0];

endmodule

// File: sv/filtered_gap_rescue_selector_unit.sv
// Top level: hit intake, rescue sequencing and output register.
//
//   channel   | dir | payload
//   ----------+-----+----------------------------------------------------
//   hit       | in  | seed_start, hit_filtered, occurrence_count, read_last
//   rescue    | out | rescued_hit_number, run_last, buffer_overflow
//   cfg_wr_*  | in  | gap threshold (write only)
//
// A hit with no rescue is sorted into the cell chain in the cycle it is
// accepted. A rescue then pops the chain head once per rescued hit, up to
// REGION_DEPTH hits; no hit is taken meanwhile. Output stalls hold the
// sequencer. Reset is synchronous, clears control state and loads the
// threshold with 100.
module filtered_gap_rescue_selector_unit import fgrs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [THR_W-1:0] cfg_wr_data,
  fgrs_hit_if.sink         hit,
  fgrs_rescue_if.source    rescue
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic              state;
  logic [THR_W-1:0]  thr;
  logic [FILL_W-1:0] fill;
  logic              ovf;
  logic [POS_W-1:0]  last_unf;
  logic [POS_W-1:0]  hit_counter;
  logic [POS_W-1:0]  dist_q;
  logic [ACC_W-1:0]  acc;

  logic [THR_W-1:0]  thr_eff;
  logic [POS_W:0]    gap;
  logic              gap_hit;
  logic              accept;
  logic              ins;
  logic              ovf_after;
  logic [FILL_W-1:0] fill_after;
  logic              do_rescue;
  logic              out_load;
  logic              emit;
  logic              emit_last;
  cell_ctl_t         ctl;
  entry_t            head;

  // Intake decode
  assign thr_eff    = (thr == '0) ? THR_W'(1) : thr;
  assign gap        = {1'b0, hit.seed_start} - {1'b0, last_unf};
  assign gap_hit    = !gap[POS_W] && (gap[POS_W-1:0] > thr_eff);
  assign hit.ready  = (state == ST_IDLE);
  assign accept     = hit.valid && hit.ready;
  assign ins        = hit.hit_filtered && (fill != FILL_W'(REGION_DEPTH));
  assign ovf_after  = ovf || (hit.hit_filtered && !ins);
  assign fill_after = fill + FILL_W'(ins);
  assign do_rescue  = gap_hit && (!hit.hit_filtered || hit.read_last)
                      && (fill_after != '0);

  // Rescue sequencing
  assign out_load  = !rescue.valid || rescue.ready;
  assign emit      = (state == ST_EMIT) && out_load;
  assign emit_last = (fill == FILL_W'(1)) || (acc > ACC_W'(dist_q));

  // Chain control
  assign ctl.insert        = accept && ins;
  assign ctl.pop           = emit;
  assign ctl.fill          = fill;
  assign ctl.new_entry.num = hit_counter;
  assign ctl.new_entry.cnt = hit.occurrence_count;

  fgrs_chain u_chain (
    .clk  (clk),
    .ctl  (ctl),
    .head (head)
  );

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // Region and read state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill        <= '0;
      ovf         <= 1'b0;
      last_unf    <= '0;
      hit_counter <= '0;
    end else if (accept) begin
      hit_counter <= hit.read_last ? '0 : hit_counter + POS_W'(1);
      if (hit.read_last) begin
        last_unf <= '0;
      end else if (!hit.hit_filtered) begin
        last_unf <= hit.seed_start;
      end
      if (do_rescue) begin
        state  <= ST_EMIT;
        fill   <= fill_after;
        ovf    <= ovf_after;
        dist_q <= gap[POS_W-1:0];
        acc    <= ACC_W'({thr_eff, 1'b0});
      end else if (!hit.hit_filtered || hit.read_last) begin
        fill <= '0;
        ovf  <= 1'b0;
      end else begin
        fill <= fill_after;
        ovf  <= ovf_after;
      end
    end else if (emit) begin
      acc <= acc + ACC_W'(thr_eff);
      if (emit_last) begin
        state <= ST_IDLE;
        fill  <= '0;
        ovf   <= 1'b0;
      end else begin
        fill <= fill - FILL_W'(1);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rescue.valid <= 1'b0;
    end else if (emit) begin
      rescue.valid <= 1'b1;
    end else if (rescue.ready) begin
      rescue.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rescue.rescued_hit_number <= head.num;
      rescue.run_last           <= emit_last;
      rescue.buffer_overflow    <= ovf;
    end
  end

endmodule

// File: test/filtered_gap_rescue_selector_unit_tb.sv
// Self-checking testbench for the filtered gap rescue selector top level.
module filtered_gap_rescue_selector_unit_tb;
  import fgrs_pkg::*;

  localparam int SETTLE_CYCLES = REGION_DEPTH + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 6;
  localparam int READS_PER_PHASE = 2;
  localparam int DIRECTED_ROWS = 19;

  // One expected rescue transaction
  typedef struct packed {
    logic [POS_W-1:0] num;
    logic             run_last;
    logic             overflow;
  } rescued_t;

  // Directed stimulus row; n and first are only compared when chk is set
  typedef struct packed {
    logic [POS_W-1:0] qs;
    logic             filtered;
    logic [CNT_W-1:0] cnt;
    logic             last;
    logic             chk;
    logic [5:0]       n;
    logic [POS_W-1:0] first;
  } hit_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [THR_W-1:0] cfg_wr_data;
  logic             rx_take;
  logic             rx_hold;

  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_go;
  int mismatches = 0;

  fgrs_hit_if    hit_ch ();
  fgrs_rescue_if rescue_ch ();

  filtered_gap_rescue_selector_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .hit         (hit_ch),
    .rescue      (rescue_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  assign rescue_ch.ready = rx_take && !rx_hold;

  // Mirror of the block's state
  logic [POS_W-1:0] region_hit_num [REGION_DEPTH];
  logic [CNT_W-1:0] region_count   [REGION_DEPTH];
  int               region_fill     = 0;
  bit               region_overflow = 1'b0;
  logic [POS_W-1:0] anchor_start    = '0;
  logic [POS_W-1:0] read_hit_num    = '0;
  logic [THR_W-1:0] rescue_thr      = THR_RESET;

  rescued_t rescued_due [$];
  rescued_t oldest_due;

  hit_row_t directed_rows [DIRECTED_ROWS] = '{
    // unfiltered start of read, no gap
    '{16'd0,     1'b0, 32'd0,          1'b0, 1'b1, 6'd0, 16'd0},
    // four filtered hits, max count, a tie, zero count
    '{16'd10,    1'b1, 32'hFFFF_FFFF,  1'b0, 1'b0, 6'd0, 16'd0},
    '{16'd20,    1'b1, 32'd5,          1'b0, 1'b0, 6'd0, 16'd0},
    '{16'd30,    1'b1, 32'd5,          1'b0, 1'b0, 6'd0, 16'd0},
    '{16'd40,    1'b1, 32'd0,          1'b0, 1'b0, 6'd0, 16'd0},
    // gap 350 at threshold 100: three lowest, tie to the earlier hit
    '{16'd350,   1'b0, 32'd7,          1'b0, 1'b1, 6'd3, 16'd4},
    '{16'd400,   1'b0, 32'd1,          1'b0, 1'b1, 6'd0, 16'd0},
    '{16'd500,   1'b1, 32'd9,          1'b0, 1'b0, 6'd0, 16'd0},
    // gap exactly at threshold: no rescue
    '{16'd500,   1'b0, 32'd2,          1'b0, 1'b1, 6'd0, 16'd0},
    '{16'd505,   1'b1, 32'd1,          1'b0, 1'b0, 6'd0, 16'd0},
    // start going backwards closes the region silently
    '{16'd300,   1'b0, 32'd8,          1'b0, 1'b1, 6'd0, 16'd0},
    '{16'd300,   1'b1, 32'd2,          1'b0, 1'b0, 6'd0, 16'd0},
    // end of read on a filtered hit at the top start
    '{16'd65535, 1'b1, 32'd3,          1'b1, 1'b1, 6'd2, 16'd11},
    // single-hit read
    '{16'd0,     1'b0, 32'd0,          1'b1, 1'b1, 6'd0, 16'd0},
    // rescue triggers with an empty buffer
    '{16'd0,     1'b0, 32'd6,          1'b0, 1'b1, 6'd0, 16'd0},
    '{16'd1000,  1'b0, 32'd6,          1'b0, 1'b1, 6'd0, 16'd0},
    '{16'd65535, 1'b0, 32'd6,          1'b1, 1'b1, 6'd0, 16'd0},
    // unfiltered last hit rescues, end check is skipped
    '{16'd0,     1'b1, 32'd4,          1'b0, 1'b0, 6'd0, 16'd0},
    '{16'd150,   1'b0, 32'd4,          1'b1, 1'b1, 6'd1, 16'd0}
  };

  // Queue the lowest-count buffered hits, ties to the lower slot
  task automatic pick_lowest_counts(input int gap_len, input int thr, inout int n,
                                    inout logic [POS_W-1:0] first);
    bit       taken [REGION_DEPTH];
    int       want;
    int       best;
    int       k;
    int       i;
    bit       found;
    rescued_t r;
    want = gap_len / thr;
    n = (want < region_fill) ? want : region_fill;
    for (i = 0; i < REGION_DEPTH; i++) taken[i] = 1'b0;
    for (k = 0; k < n; k++) begin
      best = 0;
      found = 1'b0;
      for (i = 0; i < region_fill; i++) begin
        if (!taken[i] && (!found || region_count[i] < region_count[best])) begin
          best = i;
          found = 1'b1;
        end
      end
      taken[best] = 1'b1;
      r.num = region_hit_num[best];
      r.run_last = (k + 1 == n);
      r.overflow = region_overflow;
      rescued_due.insert(rescued_due.size(), r);
      if (k == 0) first = r.num;
    end
  endtask

  // Advance the mirror by one accepted hit and queue its rescues
  task automatic predict_rescues(input logic [POS_W-1:0] qs, input logic f,
                                 input logic [CNT_W-1:0] c, input logic l,
                                 output int n, output logic [POS_W-1:0] first);
    logic [POS_W-1:0] number;
    int               thr;
    int               gap_len;
    n = 0;
    first = '0;
    thr = (rescue_thr == '0) ? 1 : int'({16'h0, rescue_thr});
    number = read_hit_num;
    read_hit_num = read_hit_num + 1'b1;
    if (f) begin
      if (region_fill < REGION_DEPTH) begin
        region_hit_num[region_fill] = number;
        region_count[region_fill] = c;
        region_fill++;
      end else begin
        region_overflow = 1'b1;
      end
    end else begin
      gap_len = int'({16'h0, qs}) - int'({16'h0, anchor_start});
      if (gap_len > thr) pick_lowest_counts(gap_len, thr, n, first);
      anchor_start = qs;
      region_fill = 0;
      region_overflow = 1'b0;
    end
    if (l) begin
      gap_len = int'({16'h0, qs}) - int'({16'h0, anchor_start});
      if (n == 0 && gap_len > thr) pick_lowest_counts(gap_len, thr, n, first);
      region_fill = 0;
      region_overflow = 1'b0;
      anchor_start = '0;
      read_hit_num = '0;
    end
  endtask

  // Offer one hit after a random gap; valid stays high into a zero gap
  task automatic send_hit(input logic [POS_W-1:0] qs, input logic f,
                          input logic [CNT_W-1:0] c, input logic l,
                          output int n, output logic [POS_W-1:0] first);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      hit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit_ch.valid            <= 1'b1;
    hit_ch.seed_start       <= qs;
    hit_ch.hit_filtered     <= f;
    hit_ch.occurrence_count <= c;
    hit_ch.read_last        <= l;
    @(posedge clk);
    while (!hit_ch.ready) @(posedge clk);
    predict_rescues(qs, f, c, l, n, first);
  endtask

  // One read: well formed, a long filtered run that overflows, or noise
  task automatic send_read(input bit broken, input bit long_run);
    int               hits;
    int               h;
    int               unit;
    int               n;
    logic [POS_W-1:0] qs;
    logic [POS_W-1:0] first;
    logic             f;
    logic             l;
    logic [CNT_W-1:0] c;
    unit = (rescue_thr == '0) ? 1 : int'({16'h0, rescue_thr});
    hits = long_run ? $urandom_range(35, 41) : $urandom_range(1, 16);
    qs = 16'($urandom_range(0, 2000));
    for (h = 0; h < hits; h++) begin
      l = (h == hits - 1);
      c = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 8));
      if (broken) begin
        qs = 16'($urandom);
        f = 1'($urandom_range(0, 1));
        l = l || ($urandom_range(0, 7) == 0);
      end else if (long_run) begin
        f = (h != 0) && !l;
        if (l) qs = qs + 16'(unit * $urandom_range(20, 40));
      end else begin
        f = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) == 0) qs = 16'($urandom);
        else if (f) qs = qs + 16'($urandom_range(0, unit / 4));
        else qs = qs + 16'(unit * $urandom_range(0, 6) + $urandom_range(0, unit));
      end
      send_hit(qs, f, c, l, n, first);
    end
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    rescue_thr = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Wait for all queued rescues, then let a rescue in flight finish
  task automatic wait_quiet();
    int guard;
    guard = 0;
    while (rescued_due.size() != 0 && guard < 400000) begin
      @(posedge clk);
      guard++;
    end
    if (rescued_due.size() != 0) begin
      $error("rescued hits never delivered: expected 0 pending, actual %0d",
             rescued_due.size());
      mismatches++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Typed-in expectation against the predicted rescue count and first hit
  task automatic confirm_rescues(input int n, input logic [POS_W-1:0] first,
                                 input int want_n, input logic [POS_W-1:0] want_first);
    if (n != want_n) begin
      $error("rescue count: expected %0d, actual %0d", want_n, n);
      mismatches++;
    end else if (n > 0 && first != want_first) begin
      $error("first rescued hit: expected %0d, actual %0d", want_first, first);
      mismatches++;
    end
  endtask

  // Rescue sink: random wait before each transaction
  initial begin : rescue_sink
    int stall;
    rx_take = 1'b0;
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        rx_take <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rx_take <= 1'b1;
      @(posedge clk);
      while (!(rescue_ch.valid && rescue_ch.ready)) @(posedge clk);
    end
  end

  // Long back-pressure stretch on request
  initial begin : rescue_hold
    int left;
    rx_hold = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        rx_hold <= 1'b1;
        for (left = HOLD_CYCLES; left > 0; left--) @(posedge clk);
        rx_hold <= 1'b0;
      end
    end
  end

  // Compare each rescue transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rescue_ch.valid && rescue_ch.ready) begin
      if (rescued_due.size() == 0) begin
        $error("rescued_hit_number: expected none, actual %0d",
               rescue_ch.rescued_hit_number);
        mismatches++;
      end else begin
        oldest_due = rescued_due.pop_front();
        if (rescue_ch.rescued_hit_number !== oldest_due.num) begin
          $error("rescued_hit_number: expected %0d, actual %0d",
                 oldest_due.num, rescue_ch.rescued_hit_number);
          mismatches++;
        end
        if (rescue_ch.run_last !== oldest_due.run_last) begin
          $error("run_last: expected %0b, actual %0b",
                 oldest_due.run_last, rescue_ch.run_last);
          mismatches++;
        end
        if (rescue_ch.buffer_overflow !== oldest_due.overflow) begin
          $error("buffer_overflow: expected %0b, actual %0b",
                 oldest_due.overflow, rescue_ch.buffer_overflow);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    int               i;
    int               p;
    int               r;
    int               n;
    logic [POS_W-1:0] first;
    logic [THR_W-1:0] thr_plan [PHASES];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hit_ch.valid = 1'b0;
    hit_ch.seed_start = '0;
    hit_ch.hit_filtered = 1'b0;
    hit_ch.occurrence_count = '0;
    hit_ch.read_last = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_go = 1'b0;
    thr_plan[0] = 16'd1;
    thr_plan[1] = 16'd0;
    thr_plan[2] = 16'd65535;
    thr_plan[3] = 16'($urandom_range(20, 400));
    thr_plan[4] = 16'($urandom_range(1, 65535));
    thr_plan[5] = 16'd37;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset threshold
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_hit(directed_rows[i].qs, directed_rows[i].filtered, directed_rows[i].cnt,
               directed_rows[i].last, n, first);
      if (directed_rows[i].chk)
        confirm_rescues(n, first, int'(directed_rows[i].n), directed_rows[i].first);
    end
    hit_ch.valid <= 1'b0;
    wait_quiet();

    // Random reads over several threshold settings
    for (p = 0; p < PHASES; p++) begin
      write_threshold(thr_plan[p]);
      if (p == 3) begin
        // sink stalls while a big rescue builds up behind it
        tx_idle_on = 1'b0;
        hold_go = 1'b1;
        send_read(1'b0, 1'b1);
        send_read(1'b0, 1'b1);
      end
      for (r = 0; r < READS_PER_PHASE; r++) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        send_read($urandom_range(0, 6) == 0, r == 0 || $urandom_range(0, 9) == 0);
      end
      hit_ch.valid <= 1'b0;
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #40000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
